@@ src/velocity_pid_feedforward_top_defines.svh @@
// Assertion macros shared by the velocity PID feedforward block.
// No dependencies; included by the files that carry assertions.
`ifndef VELOCITY_PID_FEEDFORWARD_TOP_DEFINES_SVH
`define VELOCITY_PID_FEEDFORWARD_TOP_DEFINES_SVH

// Check a property on a given clock, disabled while reset is low.
`define VPF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on the block clock and reset.
`define VPF_ASSERT(lbl, prop, msg) \
  `VPF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ src/vpf_pkg.sv @@
// Types and constants of the velocity PID feedforward block.
// No dependencies; used by every module of the block.
package vpf_pkg;

  localparam int GAIN_W     = 16;
  localparam int CAP_W      = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SPEED_W    = 16;
  localparam int ERR_W      = 17;
  localparam int ACC_W      = 26;
  localparam int DRIVE_W    = 8;
  localparam int FRAC_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_FF_GAIN    = 3'd3,
    REG_INTEG_CAP  = 3'd4
  } vpf_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [GAIN_W-1:0] ff_gain;
    logic [CAP_W-1:0]  integ_cap;
  } vpf_cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0]   integral_acc;
    logic [ERR_W-1:0]   prev_error;
    logic [SPEED_W-1:0] prev_setpoint;
  } vpf_side_state_t;

endpackage

@@ src/velocity_pid_feedforward_top.sv @@
// Two-side velocity PID controller with feedforward: one request in, one drive value out,
// a new request every clock unless out_ready_i stalls the result; an accepted request
// waits in the input register until its result is loaded into the result register. These
// two registers bound a single arithmetic pass; the per-side integral, last error and
// last setpoint are updated at the same edge that loads the result, so back-to-back
// requests on one side see each other's state. State and gains are cleared at reset.
// Depends on vpf_pkg, vpf_cfg_regs, vpf_side_state, vpf_calc and the defines header.
module velocity_pid_feedforward_top #(
  parameter int DRIVE_LIMIT = 127
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [vpf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                side_i,
  input  logic signed [vpf_pkg::SPEED_W-1:0]  setpoint_i,
  input  logic signed [vpf_pkg::SPEED_W-1:0]  measured_i,
  input  logic signed [vpf_pkg::SPEED_W-1:0]  profile_velocity_i,
  input  logic                                cruising_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_side_o,
  output logic signed [vpf_pkg::DRIVE_W-1:0]  drive_o
);
  import vpf_pkg::*;
  `include "velocity_pid_feedforward_top_defines.svh"

  vpf_cfg_t               cfg;
  vpf_side_state_t        rd_state;
  vpf_side_state_t        wr_state;
  logic [DRIVE_W-1:0]     drive_nxt;
  logic signed [37:0]     whole_sat;
  logic                   advance;

  logic                   in_valid_q;
  logic                   in_side_q;
  logic [SPEED_W-1:0]     in_sp_q;
  logic [SPEED_W-1:0]     in_meas_q;
  logic [SPEED_W-1:0]     in_pv_q;
  logic                   in_cruise_q;

  logic                   out_valid_q;
  logic                   out_side_q;
  logic [DRIVE_W-1:0]     drive_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  vpf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  vpf_side_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_side_i  (in_side_q),
    .rd_state_o (rd_state),
    .wr_en_i    (advance),
    .wr_side_i  (in_side_q),
    .wr_state_i (wr_state)
  );

  vpf_calc #(
    .DRIVE_LIMIT (DRIVE_LIMIT)
  ) u_calc (
    .cfg_i              (cfg),
    .state_i            (rd_state),
    .setpoint_i         (in_sp_q),
    .measured_i         (in_meas_q),
    .profile_velocity_i (in_pv_q),
    .cruising_i         (in_cruise_q),
    .state_o            (wr_state),
    .drive_o            (drive_nxt),
    .whole_o            (whole_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_side_q   <= side_i;
      in_sp_q     <= setpoint_i;
      in_meas_q   <= measured_i;
      in_pv_q     <= profile_velocity_i;
      in_cruise_q <= cruising_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_side_q <= in_side_q;
      drive_q    <= drive_nxt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_side_o  = out_side_q;
  assign drive_o     = drive_q;

  `VPF_ASSERT(a_drive_in_limit, advance |-> (whole_sat <= 38'(DRIVE_LIMIT) && whole_sat >= -38'(DRIVE_LIMIT)), "drive outside limit")
  `VPF_ASSERT(a_coast_clears_integ, advance && !in_cruise_q |-> wr_state.integral_acc == '0, "integral kept outside cruise")
  `VPF_ASSERT(a_integ_in_cap, advance |-> ($signed(wr_state.integral_acc) <= $signed({2'b00, cfg.integ_cap}) && $signed(wr_state.integral_acc) >= -$signed({2'b00, cfg.integ_cap})), "integral beyond cap")
  `VPF_ASSERT(a_stalled_item_held, in_valid_q && !advance |=> in_valid_q, "stalled request dropped")

endmodule

@@ src/vpf_cfg_regs.sv @@
// Gain and integral cap registers of the velocity PID feedforward block.
// Depends on vpf_pkg.
module vpf_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [vpf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output vpf_pkg::vpf_cfg_t                   cfg_o
);
  import vpf_pkg::*;

  vpf_cfg_t cfg_q;
  vpf_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (vpf_reg_e'(cfg_idx_i))
        REG_PROP_GAIN:  cfg_d.prop_gain  = cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg_d.integ_gain = cfg_data_i[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg_d.deriv_gain = cfg_data_i[GAIN_W-1:0];
        REG_FF_GAIN:    cfg_d.ff_gain    = cfg_data_i[GAIN_W-1:0];
        REG_INTEG_CAP:  cfg_d.integ_cap  = cfg_data_i[CAP_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/vpf_side_state.sv @@
// Per-side controller state: integral, last error and last setpoint.
// Depends on vpf_pkg.
module vpf_side_state (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_side_i,
  output vpf_pkg::vpf_side_state_t rd_state_o,
  input  logic                    wr_en_i,
  input  logic                    wr_side_i,
  input  vpf_pkg::vpf_side_state_t wr_state_i
);
  import vpf_pkg::*;

  vpf_side_state_t state_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q[0] <= '0;
      state_q[1] <= '0;
    end else if (wr_en_i) begin
      state_q[wr_side_i] <= wr_state_i;
    end
  end

  assign rd_state_o = state_q[rd_side_i];

endmodule

@@ src/vpf_calc.sv @@
// Single-pass PID plus feedforward arithmetic for one request.
// Depends on vpf_pkg.
module vpf_calc #(
  parameter int DRIVE_LIMIT = 127
) (
  input  vpf_pkg::vpf_cfg_t                cfg_i,
  input  vpf_pkg::vpf_side_state_t         state_i,
  input  logic [vpf_pkg::SPEED_W-1:0]      setpoint_i,
  input  logic [vpf_pkg::SPEED_W-1:0]      measured_i,
  input  logic [vpf_pkg::SPEED_W-1:0]      profile_velocity_i,
  input  logic                             cruising_i,
  output vpf_pkg::vpf_side_state_t         state_o,
  output logic [vpf_pkg::DRIVE_W-1:0]      drive_o,
  output logic signed [37:0]               whole_o
);
  import vpf_pkg::*;

  localparam int PROD_W = 2 * ERR_W;
  localparam int I_W    = PROD_W + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int D_W    = GAIN_W + 1 + DIFF_W;
  localparam int FF_W   = GAIN_W + 1 + SPEED_W;
  localparam int SUM_W  = 38;
  localparam logic signed [SUM_W-1:0] LIMIT   = SUM_W'(DRIVE_LIMIT);
  localparam logic signed [SUM_W-1:0] ROUNDUP = SUM_W'((1 << FRAC_W) - 1);

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [ACC_W-1:0]  acc;
  logic                     new_sp;
  logic                     sign_flip;
  logic signed [PROD_W-1:0] p_prod;
  logic signed [PROD_W-1:0] i_prod;
  logic signed [I_W-1:0]    i_raw;
  logic signed [I_W-1:0]    cap;
  logic signed [I_W-1:0]    i_clamp;
  logic signed [DIFF_W-1:0] diff;
  logic signed [D_W-1:0]    d_prod;
  logic signed [FF_W-1:0]   ff_prod;
  logic signed [SUM_W-1:0]  p_term;
  logic signed [SUM_W-1:0]  i_term;
  logic signed [SUM_W-1:0]  d_term;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  whole;
  logic signed [SUM_W-1:0]  sat;

  assign err = ERR_W'($signed(setpoint_i)) - ERR_W'($signed(measured_i));
  assign new_sp = (setpoint_i != state_i.prev_setpoint);
  assign prev_err = new_sp ? '0 : $signed(state_i.prev_error);
  assign sign_flip = ((err > 0) && (prev_err < 0)) || ((err < 0) && (prev_err > 0));
  assign acc = (new_sp || sign_flip) ? '0 : $signed(state_i.integral_acc);

  assign p_prod  = $signed({1'b0, cfg_i.prop_gain}) * err;
  assign i_prod  = $signed({1'b0, cfg_i.integ_gain}) * err;
  assign diff    = DIFF_W'(err) - DIFF_W'(prev_err);
  assign d_prod  = $signed({1'b0, cfg_i.deriv_gain}) * diff;
  assign ff_prod = $signed({1'b0, cfg_i.ff_gain}) * $signed(profile_velocity_i);

  assign i_raw = I_W'(acc) + I_W'(i_prod);
  assign cap   = $signed({{(I_W - CAP_W){1'b0}}, cfg_i.integ_cap});

  always_comb begin
    if (i_raw > cap) begin
      i_clamp = cap;
    end else if (i_raw < -cap) begin
      i_clamp = -cap;
    end else begin
      i_clamp = i_raw;
    end
  end

  always_comb begin
    p_term = '0;
    i_term = '0;
    d_term = '0;
    if (cruising_i) begin
      p_term = (p_prod < 0) ? '0 : SUM_W'(p_prod);
      i_term = SUM_W'(i_clamp);
      d_term = SUM_W'(d_prod);
    end
  end

  assign sum   = p_term + i_term + d_term + SUM_W'(ff_prod);
  assign whole = (sum < 0) ? ((sum + ROUNDUP) >>> FRAC_W) : (sum >>> FRAC_W);

  always_comb begin
    if (whole > LIMIT) begin
      sat = LIMIT;
    end else if (whole < -LIMIT) begin
      sat = -LIMIT;
    end else begin
      sat = whole;
    end
  end

  assign state_o.integral_acc  = i_term[ACC_W-1:0];
  assign state_o.prev_error    = err;
  assign state_o.prev_setpoint = setpoint_i;
  assign drive_o = sat[DRIVE_W-1:0];
  assign whole_o = sat;

endmodule

@@ sim/velocity_pid_feedforward_top_tb.sv @@
// Self-checking bench for velocity_pid_feedforward_top: gain phases, directed and random requests.
// A bit-true predictor fills a queue of expected drive values that the result monitor drains.
// Depends on vpf_pkg and velocity_pid_feedforward_top.
`timescale 1ns / 100ps

module velocity_pid_feedforward_top_tb;
  import vpf_pkg::*;

  localparam int DRIVE_LIMIT  = 127;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 190;

  typedef struct packed {
    logic                      side;
    logic signed [SPEED_W-1:0] setpoint;
    logic signed [SPEED_W-1:0] measured;
    logic signed [SPEED_W-1:0] profile_velocity;
    logic                      cruising;
  } request_t;

  typedef struct packed {
    logic                      out_side;
    logic signed [DRIVE_W-1:0] drive;
  } drive_t;

  logic                      clk_i              = 1'b0;
  logic                      rst_ni             = 1'b0;
  logic                      cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i          = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i         = '0;
  logic                      in_valid_i         = 1'b0;
  logic                      in_ready_o;
  logic                      side_i             = 1'b0;
  logic signed [SPEED_W-1:0] setpoint_i         = '0;
  logic signed [SPEED_W-1:0] measured_i         = '0;
  logic signed [SPEED_W-1:0] profile_velocity_i = '0;
  logic                      cruising_i         = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i        = 1'b0;
  logic                      out_side_o;
  logic signed [DRIVE_W-1:0] drive_o;

  vpf_cfg_t                  gains = '0;
  logic signed [ACC_W-1:0]   integ_state   [2] = '{'0, '0};
  logic signed [ERR_W-1:0]   err_hist      [2] = '{'0, '0};
  logic signed [SPEED_W-1:0] last_setpoint [2] = '{'0, '0};

  request_t    pending_requests[$];
  drive_t      expected_drives[$];
  request_t    offered_req = '0;
  drive_t      want;
  int          sp_run [2] = '{0, 0};
  int unsigned send_gap   = 0;
  int unsigned send_calm  = 0;
  int unsigned recv_hold  = 0;
  int unsigned recv_calm  = 0;
  int unsigned recv_wait;
  int unsigned fail_count = 0;

  velocity_pid_feedforward_top #(
    .DRIVE_LIMIT(DRIVE_LIMIT)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .side_i,
    .setpoint_i,
    .measured_i,
    .profile_velocity_i,
    .cruising_i,
    .out_valid_o,
    .out_ready_i,
    .out_side_o,
    .drive_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic drive_t predict_drive(request_t req);
    longint err, prior, acc, cap, p_term, i_term, d_term, ff_term, sum, whole;
    drive_t res;
    err   = longint'(req.setpoint) - longint'(req.measured);
    acc   = integ_state[req.side];
    prior = err_hist[req.side];
    if (req.setpoint != last_setpoint[req.side]) begin
      acc   = 0;
      prior = 0;
    end
    if ((err > 0 && prior < 0) || (err < 0 && prior > 0)) acc = 0;
    cap     = longint'(gains.integ_cap);
    p_term  = longint'(gains.prop_gain) * err;
    i_term  = acc + longint'(gains.integ_gain) * err;
    if (i_term > cap) i_term = cap;
    if (i_term < -cap) i_term = -cap;
    d_term  = longint'(gains.deriv_gain) * (err - prior);
    ff_term = longint'(gains.ff_gain) * longint'(req.profile_velocity);
    if (!req.cruising) begin
      p_term = 0;
      i_term = 0;
      d_term = 0;
    end
    if (p_term < 0) p_term = 0;
    integ_state[req.side] = ACC_W'(i_term);
    sum   = p_term + i_term + d_term + ff_term;
    whole = (sum < 0) ? -((-sum) >>> FRAC_W) : (sum >>> FRAC_W);
    if (whole > DRIVE_LIMIT) whole = DRIVE_LIMIT;
    if (whole < -DRIVE_LIMIT) whole = -DRIVE_LIMIT;
    err_hist[req.side]      = ERR_W'(err);
    last_setpoint[req.side] = req.setpoint;
    res.out_side = req.side;
    res.drive    = DRIVE_W'(whole);
    return res;
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic request_t mk_request(bit side, int sp, int meas, int pv, bit cruise);
    request_t r;
    r.side             = side;
    r.setpoint         = SPEED_W'(sp);
    r.measured         = SPEED_W'(meas);
    r.profile_velocity = SPEED_W'(pv);
    r.cruising         = cruise;
    return r;
  endfunction

  // mostly steady setpoints with small errors so the integral builds up; the rest is noise
  function automatic request_t rand_request();
    bit s;
    int sp;
    s = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 3) == 0) sp_run[s] = int'($urandom_range(0, 65535)) - 32768;
        else sp_run[s] = int'($urandom_range(0, 4000)) - 2000;
      end
      sp = sp_run[s];
      return mk_request(s, sp, sp - (int'($urandom_range(0, 600)) - 300),
                        int'($urandom_range(0, 4000)) - 2000, $urandom_range(0, 7) != 0);
    end
    return mk_request(s, int'($urandom()), int'($urandom()), int'($urandom()),
                      1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom_range(0, 16'h0040));
      3:       return GAIN_W'($urandom_range(0, 16'h01FF));
      default: return GAIN_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_cap();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return CAP_W'($urandom_range(0, 24'h004000));
      default: return CAP_W'($urandom());
    endcase
  endfunction

  task automatic load_gains(input vpf_cfg_t g);
    vpf_reg_e              idx [5] = '{REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN,
                                       REG_FF_GAIN, REG_INTEG_CAP};
    logic [CFG_DATA_W-1:0] val [5];
    val[0] = {8'($urandom()), g.prop_gain};
    val[1] = {8'($urandom()), g.integ_gain};
    val[2] = {8'($urandom()), g.deriv_gain};
    val[3] = {8'($urandom()), g.ff_gain};
    val[4] = g.integ_cap;
    for (int k = 0; k < 5; k++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= val[k];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gains = g;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_drives.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // request side: hold until accepted, then idle for the drawn gap before the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_drives.push_back(predict_drive(offered_req));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pending_requests.size() != 0) begin
          offered_req         = pending_requests.pop_front();
          side_i             <= offered_req.side;
          setpoint_i         <= offered_req.setpoint;
          measured_i         <= offered_req.measured;
          profile_velocity_i <= offered_req.profile_velocity;
          cruising_i         <= offered_req.cruising;
          in_valid_i         <= 1'b1;
          send_gap           <= draw_wait(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side: check each accepted drive value, then stall for the drawn count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_drives.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result side %0d drive %0d", $time, out_side_o, drive_o);
        end else begin
          want = expected_drives.pop_front();
          if (out_side_o !== want.out_side) begin
            fail_count++;
            $display("%0t: side expected %0d actual %0d", $time, want.out_side, out_side_o);
          end
          if (drive_o !== want.drive) begin
            fail_count++;
            $display("%0t: drive expected %0d actual %0d", $time, want.drive, drive_o);
          end
        end
        recv_wait    = draw_wait(recv_calm);
        recv_hold   <= recv_wait;
        out_ready_i <= (recv_wait == 0);
      end else if (recv_hold > 0) begin
        recv_hold   <= recv_hold - 1;
        out_ready_i <= (recv_hold == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    vpf_cfg_t g;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // gains still at reset
    pending_requests.push_back(mk_request(0, 500, -500, 32767, 1));
    pending_requests.push_back(mk_request(1, -32768, 32767, -32768, 1));
    pending_requests.push_back(mk_request(0, 0, 0, 0, 0));
    wait_idle();

    g = '{prop_gain: 16'h0100, integ_gain: 16'h0020, deriv_gain: 16'h0080,
          ff_gain: 16'h0001, integ_cap: 24'h001000};
    load_gains(g);
    pending_requests.push_back(mk_request(0, 100, 90, 0, 1));
    pending_requests.push_back(mk_request(0, 100, 95, 0, 1));
    pending_requests.push_back(mk_request(0, 100, 97, 0, 1));
    pending_requests.push_back(mk_request(0, 100, 110, 0, 1));
    pending_requests.push_back(mk_request(0, 100, 100, 0, 1));
    pending_requests.push_back(mk_request(0, 100, 104, 0, 1));
    pending_requests.push_back(mk_request(0, 100, 105, 800, 0));
    pending_requests.push_back(mk_request(0, 120, 105, 0, 1));
    pending_requests.push_back(mk_request(1, -32768, 32767, -32768, 1));
    pending_requests.push_back(mk_request(1, 32767, -32768, 32767, 1));
    pending_requests.push_back(mk_request(1, 0, 0, -300, 0));
    pending_requests.push_back(mk_request(1, 0, 0, -300, 1));
    pending_requests.push_back(mk_request(0, -1, -1, -1, 1));
    pending_requests.push_back(mk_request(1, 32767, 32767, 255, 1));
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       g = '{prop_gain: '1, integ_gain: '1, deriv_gain: '1, ff_gain: '1,
                       integ_cap: '1};
        1:       g = '0;
        default: g = '{prop_gain: pick_gain(), integ_gain: pick_gain(),
                       deriv_gain: pick_gain(), ff_gain: pick_gain(), integ_cap: pick_cap()};
      endcase
      load_gains(g);
      for (int n = 0; n < PHASE_ITEMS; n++) pending_requests.push_back(rand_request());
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/vpf_pkg.sv
src/vpf_cfg_regs.sv
src/vpf_side_state.sv
src/vpf_calc.sv
src/velocity_pid_feedforward_top.sv
sim/velocity_pid_feedforward_top_tb.sv
